// ----- hw/rtl/odm_pkg.sv -----
// ---------------------------------------------------------------------------
// odm_pkg
// Shared types, constants and tag decoding for the OSC message deframer.
// ---------------------------------------------------------------------------
package odm_pkg;

   localparam int MAX_ARGS        = 16;
   localparam int MAX_FIELD_BYTES = 2048;

   localparam int ARG_W = $clog2(MAX_ARGS + 1);
   localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam int BUF_W = $clog2(MAX_FIELD_BYTES + 1);

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_ADDR_BYTE = 3'd1;
   localparam logic [2:0] EV_ADDR_END  = 3'd2;
   localparam logic [2:0] EV_TYPE      = 3'd3;
   localparam logic [2:0] EV_FIXED     = 3'd4;
   localparam logic [2:0] EV_PAYLOAD   = 3'd5;
   localparam logic [2:0] EV_VAR_END   = 3'd6;
   localparam logic [2:0] EV_IGNORED   = 3'd7;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_BUF_FULL = 2'd1;
   localparam logic [1:0] ERR_TAGS     = 2'd2;

   typedef enum logic [2:0] {
      PH_STANDBY   = 3'd0,
      PH_ADDRESS   = 3'd1,
      PH_ADDR_PAD  = 3'd2,
      PH_TYPES     = 3'd3,
      PH_TYPES_PAD = 3'd4,
      PH_DATA      = 3'd5,
      PH_DATA_PAD  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_FIX4,
      KIND_FIX8,
      KIND_STRING,
      KIND_BLOB,
      KIND_UNKNOWN
   } kind_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  byte_value;
      logic [3:0]  arg_index;
      logic [7:0]  type_tag;
      logic [63:0] arg_value;
      logic [1:0]  error_code;
   } result_type;

   function automatic kind_type tag_kind(input logic [7:0] t);
      kind_type k;
      unique case (t)
         8'h69, 8'h66, 8'h72, 8'h6D: k = KIND_FIX4;
         8'h68, 8'h64, 8'h74:        k = KIND_FIX8;
         8'h54, 8'h46, 8'h4E, 8'h49: k = KIND_NONE;
         8'h73:                      k = KIND_STRING;
         8'h62:                      k = KIND_BLOB;
         default:                    k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

// ----- hw/rtl/odm_ram.sv -----
// ---------------------------------------------------------------------------
// odm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module odm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/odm_core.sv -----
// ---------------------------------------------------------------------------
// odm_core
// Per-byte phase walker; type tags live in a RAM that is read ahead of use.
// ---------------------------------------------------------------------------
module odm_core
   import odm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       restart,
   output result_type result
);

   phase_type          phase_ff, phase_in, eff_phase;
   logic [ARG_W-1:0]   count_ff, count_in, eff_count;
   logic [ARG_W-1:0]   arg_ff, arg_in, eff_arg;
   logic [BUF_W-1:0]   buf_ff, buf_in, eff_buf, buf_inc;
   logic [63:0]        asm_ff, asm_in, eff_asm, asm_shift, asm_inc;
   logic [31:0]        blen_ff, blen_in, eff_blen, blen_now;
   logic [1:0]         pad_ff, pad_in, eff_pad;
   logic [1:0]         err_ff, err_in, eff_err, err_a;
   logic [MAX_ARGS-1:0] empty_ff, empty_in, mask_cur;
   logic               byp_ff;
   logic [7:0]         byp_data_ff;

   logic               full, added, arg_ok, data_now;
   logic [7:0]         ram_rdata, cur_tag;
   kind_type           kind;
   logic               fixed_done, str_end, blob_hdr, blob_stop, blob_end, finish;
   logic               tag_store, types_done;
   logic [ARG_W-1:0]   count_n, skip_start, skip_res;
   logic [1:0]         tp_pad;
   logic [2:0]         tp;
   logic [ARG_W+BUF_W:0] types_target, buf_cmp;
   logic [32:0]        blob_target;
   logic               ram_we, byp_in;
   logic [IDX_W-1:0]   ram_waddr, ram_raddr;

   // Effective state: restart returns phase, counters and error to reset before the byte.
   always_comb begin
      if (restart) begin
         eff_phase = PH_STANDBY;
         eff_count = '0;
         eff_arg   = '0;
         eff_buf   = '0;
         eff_asm   = '0;
         eff_blen  = '0;
         eff_pad   = '0;
         eff_err   = ERR_OK;
      end else begin
         eff_phase = phase_ff;
         eff_count = count_ff;
         eff_arg   = arg_ff;
         eff_buf   = buf_ff;
         eff_asm   = asm_ff;
         eff_blen  = blen_ff;
         eff_pad   = pad_ff;
         eff_err   = err_ff;
      end
   end

   // First argument at or after start that takes data bytes.
   function automatic logic [ARG_W-1:0] skip_empty(input logic [ARG_W-1:0] start,
                                                   input logic [ARG_W-1:0] cnt,
                                                   input logic [MAX_ARGS-1:0] mask);
      logic [ARG_W-1:0] res;
      res = (start >= cnt) ? start : cnt;
      for (int j = MAX_ARGS - 1; j >= 0; j--) begin
         if (ARG_W'(j) >= start && ARG_W'(j) < cnt && !mask[j]) begin
            res = ARG_W'(j);
         end
      end
      return res;
   endfunction

   // Decision signals shared by the next-phase and datapath blocks.
   always_comb begin
      full      = (eff_buf >= BUF_W'(MAX_FIELD_BYTES));
      added     = !full;
      buf_inc   = full ? eff_buf : eff_buf + BUF_W'(1);
      err_a     = (full && eff_err == ERR_OK) ? ERR_BUF_FULL : eff_err;
      cur_tag   = byp_ff ? byp_data_ff : ram_rdata;
      arg_ok    = (eff_arg < eff_count);
      kind      = tag_kind(cur_tag);
      data_now  = (eff_phase == PH_DATA) || (eff_phase == PH_DATA_PAD && eff_pad == 2'd0);
      asm_shift = {eff_asm[55:0], data_byte};
      asm_inc   = eff_asm + 64'd1;

      fixed_done = ((kind == KIND_FIX4) && buf_inc == BUF_W'(4)) ||
                   ((kind == KIND_FIX8) && buf_inc == BUF_W'(8));
      str_end    = (kind == KIND_STRING) && (data_byte == 8'd0);
      blob_hdr   = added && (buf_inc <= BUF_W'(4));
      blob_stop  = blob_hdr && (buf_inc < BUF_W'(4));
      blen_now   = (blob_hdr && buf_inc == BUF_W'(4)) ? asm_shift[31:0] : eff_blen;
      blob_target = {1'b0, blen_now} + 33'd4;
      blob_end   = (kind == KIND_BLOB) && !blob_stop &&
                   (33'(buf_inc) == blob_target);
      finish     = data_now && arg_ok && (fixed_done || str_end || blob_end);

      tag_store  = (eff_phase == PH_TYPES) && (data_byte != 8'd0) &&
                   (eff_count < ARG_W'(MAX_ARGS));
      count_n    = tag_store ? eff_count + ARG_W'(1) : eff_count;
      tp_pad     = 2'd0 - (count_n[1:0] + 2'd1);
      tp         = (tp_pad == 2'd0) ? 3'd4 : {1'b0, tp_pad};
      types_target = (ARG_W+BUF_W+1)'(count_n) + (ARG_W+BUF_W+1)'(tp);
      buf_cmp    = (ARG_W+BUF_W+1)'(buf_inc);
      types_done = (eff_phase == PH_TYPES || eff_phase == PH_TYPES_PAD) &&
                   (buf_cmp == types_target);

      mask_cur = empty_ff;
      if (tag_store) begin
         mask_cur[eff_count[IDX_W-1:0]] = (tag_kind(data_byte) == KIND_NONE);
      end
      skip_start = finish ? eff_arg + ARG_W'(1) : '0;
      skip_res   = skip_empty(skip_start, count_n, mask_cur);
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (eff_phase)
            PH_STANDBY:   phase_in = (data_byte == CHAR_SLASH) ? PH_ADDRESS : PH_STANDBY;
            PH_ADDRESS:   phase_in = (data_byte == 8'd0) ? PH_ADDR_PAD : PH_ADDRESS;
            PH_ADDR_PAD:  phase_in = (data_byte == CHAR_COMMA) ? PH_TYPES : PH_ADDR_PAD;
            PH_TYPES: begin
               phase_in = (data_byte == 8'd0) ? PH_TYPES_PAD : PH_TYPES;
               if (types_done) phase_in = PH_DATA;
            end
            PH_TYPES_PAD: phase_in = types_done ? PH_DATA : PH_TYPES_PAD;
            PH_DATA:      phase_in = (finish && !fixed_done) ? PH_DATA_PAD : PH_DATA;
            PH_DATA_PAD: begin
               if (eff_pad == 2'd0) begin
                  phase_in = (finish && !fixed_done) ? PH_DATA_PAD : PH_DATA;
               end else if (buf_inc == BUF_W'(eff_pad)) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_DATA_PAD;
               end
            end
            default:      phase_in = PH_STANDBY;
         endcase
      end
   end

   // Datapath and result.
   always_comb begin
      count_in = count_ff;
      arg_in   = arg_ff;
      buf_in   = buf_ff;
      asm_in   = asm_ff;
      blen_in  = blen_ff;
      pad_in   = pad_ff;
      err_in   = err_ff;
      empty_in = empty_ff;
      result   = '0;
      if (accept) begin
         count_in = count_n;
         arg_in   = eff_arg;
         buf_in   = buf_inc;
         asm_in   = eff_asm;
         blen_in  = eff_blen;
         pad_in   = eff_pad;
         err_in   = err_a;
         empty_in = mask_cur;
         result.byte_value = data_byte;
         result.event_res  = EV_NONE;
         unique case (eff_phase)
            PH_STANDBY: begin
               result.event_res = (data_byte == CHAR_SLASH) ? EV_ADDR_BYTE : EV_IGNORED;
            end
            PH_ADDRESS: begin
               if (data_byte == 8'd0) begin
                  result.event_res = EV_ADDR_END;
                  buf_in = '0;
                  asm_in = '0;
               end else begin
                  result.event_res = EV_ADDR_BYTE;
               end
            end
            PH_ADDR_PAD: begin
               if (data_byte == CHAR_COMMA) begin
                  buf_in = '0;
                  asm_in = '0;
                  arg_in = '0;
               end
            end
            PH_TYPES, PH_TYPES_PAD: begin
               if (eff_phase == PH_TYPES && data_byte != 8'd0) begin
                  if (tag_store) begin
                     result.event_res = EV_TYPE;
                     result.arg_index = eff_count[3:0];
                     result.type_tag  = data_byte;
                  end else begin
                     result.event_res = EV_IGNORED;
                     if (err_a == ERR_OK) err_in = ERR_TAGS;
                  end
               end
               if (types_done) begin
                  buf_in = '0;
                  asm_in = '0;
                  arg_in = skip_res;
               end
            end
            PH_DATA, PH_DATA_PAD: begin
               if (data_now) begin
                  if (!arg_ok) begin
                     result.event_res = EV_IGNORED;
                  end else begin
                     result.arg_index = eff_arg[3:0];
                     result.type_tag  = cur_tag;
                     unique case (kind)
                        KIND_FIX4, KIND_FIX8: begin
                           asm_in = asm_shift;
                           if (fixed_done) begin
                              result.event_res = EV_FIXED;
                              result.arg_value = asm_shift;
                           end
                        end
                        KIND_STRING: begin
                           asm_in = asm_inc;
                           if (str_end) begin
                              result.event_res = EV_VAR_END;
                              pad_in = 2'd0 - asm_inc[1:0];
                           end else begin
                              result.event_res = EV_PAYLOAD;
                           end
                        end
                        KIND_BLOB: begin
                           if (blob_hdr) begin
                              asm_in  = asm_shift;
                              blen_in = blen_now;
                           end else begin
                              result.event_res = EV_PAYLOAD;
                           end
                           if (blob_end) begin
                              result.event_res = EV_VAR_END;
                              pad_in = 2'd0 - blen_now[1:0];
                           end
                        end
                        default: result.event_res = EV_IGNORED;
                     endcase
                     if (finish) begin
                        buf_in = '0;
                        asm_in = '0;
                        arg_in = skip_res;
                     end
                  end
               end else if (buf_inc == BUF_W'(eff_pad)) begin
                  buf_in = '0;
                  asm_in = '0;
               end
            end
            default: result.event_res = EV_IGNORED;
         endcase
         result.error_code = err_in;
      end
   end

   // Tag RAM: the read address follows the argument of the next byte.
   always_comb begin
      ram_we    = accept && tag_store;
      ram_waddr = eff_count[IDX_W-1:0];
      ram_raddr = arg_in[IDX_W-1:0];
      byp_in    = ram_we && (ram_waddr == ram_raddr);
   end

   odm_ram #(
      .WIDTH(8),
      .DEPTH(MAX_ARGS)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(data_byte),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STANDBY;
         count_ff <= '0;
         arg_ff   <= '0;
         buf_ff   <= '0;
         asm_ff   <= '0;
         blen_ff  <= '0;
         pad_ff   <= '0;
         err_ff   <= ERR_OK;
         empty_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         arg_ff   <= arg_in;
         buf_ff   <= buf_in;
         asm_ff   <= asm_in;
         blen_ff  <= blen_in;
         pad_ff   <= pad_in;
         err_ff   <= err_in;
         empty_ff <= empty_in;
         byp_ff   <= byp_in;
      end
      byp_data_ff <= data_byte;
   end

endmodule

// ----- hw/rtl/odm_outq.sv -----
// ---------------------------------------------------------------------------
// odm_outq
// Two-entry result queue that lets the input side keep going under stall.
// ---------------------------------------------------------------------------
module odm_outq
   import odm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   result_type q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   always_comb begin
      pop    = (cnt_ff != 2'd0) && !out_stall;
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q0_in  = q1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) begin
            q0_in = push_data;
         end else begin
            q1_in = push_data;
         end
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = q0_ff;

endmodule

// ----- hw/rtl/osc_message_deframer.sv -----
// Output: each result item is registered in the output queue on acceptance.
// Throughput: one byte per cycle unless the queue is full; the tag RAM is
// read ahead; a write-to-read bypass covers a tag written while it is read.
// Reset: synchronous, active high; clears the decoder's control state and the queue.
// A byte with restart set decodes from the reset state.
// ---------------------------------------------------------------------------
// osc_message_deframer
// Byte-serial OSC message decoder with one result item per input byte.
// ---------------------------------------------------------------------------
module osc_message_deframer
   import odm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_byte_value,
   output logic [3:0]  rsp_arg_index,
   output logic [7:0]  rsp_type_tag,
   output logic [63:0] rsp_arg_value,
   output logic [1:0]  rsp_error_code
);

   logic       accept, q_full;
   result_type res, q_out;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;

   odm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .data_byte(req_data_byte),
      .restart  (req_restart),
      .result   (res)
   );

   odm_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_data(res),
      .full     (q_full),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (q_out)
   );

   assign rsp_event_res  = q_out.event_res;
   assign rsp_byte_value = q_out.byte_value;
   assign rsp_arg_index  = q_out.arg_index;
   assign rsp_type_tag   = q_out.type_tag;
   assign rsp_arg_value  = q_out.arg_value;
   assign rsp_error_code = q_out.error_code;

endmodule
